>>> rtl/rfx_pkg.sv
package rfx_pkg;

  localparam int RING_DEPTH_DEF    = 64;
  localparam int MAX_FRAME_LEN_DEF = 24;

  localparam logic [7:0]  EMPTY_MARK  = 8'd255;
  localparam logic [8:0]  HEADER_BASE = 9'd250;
  localparam logic [15:0] COUNT_CAP   = 16'd65500;
  localparam logic [6:0]  RESULT_ROOM = 7'd48;

  localparam logic [2:0] FRAME_ID_RESET  = 3'd0;
  localparam logic [5:0] RESYNC_RESET    = 6'd30;
  localparam logic [4:0] FRAME_LEN_RESET = 5'd12;

  localparam logic [1:0] REG_FRAME_ID  = 2'd0;
  localparam logic [1:0] REG_RESYNC    = 2'd1;
  localparam logic [1:0] REG_FRAME_LEN = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    OUTCOME_NORMAL  = 2'd0,
    OUTCOME_STALLED = 2'd1,
    OUTCOME_OVERRUN = 2'd2
  } outcome_t;

  typedef enum logic {
    PTR_INC = 1'b0,
    PTR_SUB = 1'b1
  } ptr_op_t;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_CLASSIFY,
    SEQ_SCAN_CHECK,
    SEQ_SCAN_STEP,
    SEQ_SCAN_TEST,
    SEQ_DATA_STEP,
    SEQ_DATA_EMIT,
    SEQ_FRAME_END,
    SEQ_STATUS
  } seq_state_t;

endpackage

>>> rtl/rfx_ptr_unit.sv
module rfx_ptr_unit import rfx_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int PW = $clog2(RING_DEPTH)
) (
  input  ptr_op_t       op,
  input  logic [PW-1:0] a,
  input  logic [PW-1:0] b,
  output logic [PW-1:0] res
);

  localparam int PW1 = PW + 1;
  localparam logic [PW:0] DEPTH_W = PW1'(RING_DEPTH);
  localparam logic [PW:0] ONE_W   = PW1'(1);

  logic [PW:0] a_ext;
  logic [PW:0] b_ext;
  logic [PW:0] sum;

  always_comb begin
    a_ext = {1'b0, a};
    b_ext = {1'b0, b};
    unique case (op)
      PTR_INC: sum = (a_ext == DEPTH_W - ONE_W) ? '0 : a_ext + ONE_W;
      PTR_SUB: sum = (a_ext >= b_ext) ? a_ext - b_ext : a_ext + DEPTH_W - b_ext;
      default: sum = '0;
    endcase
    res = sum[PW-1:0];
  end

endmodule

>>> rtl/rfx_ring.sv
module rfx_ring import rfx_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int PW = $clog2(RING_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [PW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          clr_en,
  input  logic [PW-1:0] clr_addr,
  input  logic [PW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]            mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;
  logic [7:0]            rd_q;
  logic                  rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        vld[clr_addr] <= 1'b0;
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : EMPTY_MARK;

endmodule

>>> rtl/ring_frame_extractor.sv
// Channel  Valid         Stall         Payload
// item     item_valid    item_stall    opcode, link_byte
// result   result_valid  result_stall  item_kind, byte_index, frame_byte, poll_outcome,
//                                      stall_total, overrun_total, reader_position,
//                                      last_of_run
// config   cfg_we        -             cfg_index, cfg_data
//
// A link byte is written into the ring while the sequencer is idle. A poll runs load and classify,
// then scan check, step and test per scanned ring entry, data step and emit per data byte,
// frame end per frame and a status step, sharing the single pointer unit and the registered ring read port.
// Reset clears all ring valid bits together; item_stall is high for a whole poll.
// No clearing pass. A stalled result holds the sequencer at its data emit or status step.
module ring_frame_extractor import rfx_pkg::*; #(
  parameter int RING_DEPTH       = RING_DEPTH_DEF,
  parameter int MAX_FRAME_LENGTH = MAX_FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        opcode,
  input  logic [7:0]  link_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        item_kind,
  output logic [4:0]  byte_index,
  output logic [7:0]  frame_byte,
  output logic [1:0]  poll_outcome,
  output logic [15:0] stall_total,
  output logic [15:0] overrun_total,
  output logic [5:0]  reader_position,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int EW = PW + 2;
  localparam logic [EW-1:0] DEPTH_E = EW'(RING_DEPTH);
  localparam logic [EW-1:0] HALF_E  = EW'(RING_DEPTH / 2);
  localparam logic [4:0]    LEN_MAX = 5'(MAX_FRAME_LENGTH);

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c >= COUNT_CAP) ? COUNT_CAP : c + 16'd1;
  endfunction

  seq_state_t    state;
  seq_state_t    state_next;
  logic [PW-1:0] w;
  logic [PW-1:0] prev_w;
  logic [PW-1:0] r;
  logic [15:0]   stall_cnt;
  logic [15:0]   ov_cnt;
  outcome_t      outcome;
  logic [4:0]    byte_idx;
  logic [5:0]    n_cnt;
  logic [2:0]    frame_id;
  logic [5:0]    resync;
  logic [4:0]    frame_len;

  ptr_op_t       ptr_op;
  logic [PW-1:0] ptr_a;
  logic [PW-1:0] ptr_b;
  logic [PW-1:0] ptr_res;

  logic          wr_en;
  logic          clr_en;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic [EW-1:0] rs_e;
  logic [EW-1:0] rs_mod;
  logic [PW-1:0] rs_mod_p;
  logic [4:0]    stop_gap;
  logic [4:0]    len;
  logic          out_load;
  logic          is_empty;
  logic          is_header;
  logic          gap_done;
  logic          frame_stop;
  logic          last_byte;
  logic          load_data;
  logic          load_status;

  rfx_ptr_unit #(.RING_DEPTH(RING_DEPTH)) u_ptr (
    .op  (ptr_op),
    .a   (ptr_a),
    .b   (ptr_b),
    .res (ptr_res)
  );

  rfx_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (w),
    .wr_data  (link_byte),
    .clr_en   (clr_en),
    .clr_addr (r),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  assign item_stall = (state != SEQ_IDLE);
  assign wr_en      = (state == SEQ_IDLE) && item_valid && !opcode;
  assign out_load   = !result_valid || !result_stall;

  assign rs_e       = EW'(resync);
  assign rs_mod     = (rs_e >= DEPTH_E) ? rs_e - DEPTH_E : rs_e;
  assign rs_mod_p   = rs_mod[PW-1:0];
  assign stop_gap   = resync[5:1];
  assign len        = (frame_len > LEN_MAX) ? LEN_MAX : frame_len;

  assign is_empty   = (rd_data == EMPTY_MARK);
  assign is_header  = ({1'b0, rd_data} == HEADER_BASE + {6'b0, frame_id});
  assign gap_done   = (EW'(ptr_res) <= EW'(stop_gap));
  assign frame_stop = (EW'(ptr_res) < HALF_E) ||
                      (({1'b0, n_cnt} + {2'b0, len}) > RESULT_ROOM);
  assign last_byte  = (byte_idx == len - 5'd1);

  assign load_data   = (state == SEQ_DATA_EMIT) && out_load;
  assign load_status = (state == SEQ_STATUS) && out_load;

  always_comb begin
    ptr_op  = PTR_INC;
    ptr_a   = r;
    ptr_b   = w;
    rd_addr = r;
    clr_en  = 1'b0;
    unique case (state) inside
      SEQ_IDLE: begin
        ptr_a = w;
      end
      SEQ_LOAD: begin
        ptr_a = w;
        if (w == r) begin
          rd_addr = ptr_res;
        end
      end
      SEQ_CLASSIFY: begin
        ptr_op = PTR_SUB;
        ptr_a  = w;
        ptr_b  = rs_mod_p;
      end
      SEQ_SCAN_CHECK, SEQ_FRAME_END: begin
        ptr_op = PTR_SUB;
        ptr_a  = w;
        ptr_b  = r;
      end
      SEQ_SCAN_STEP, SEQ_DATA_STEP: begin
        rd_addr = ptr_res;
      end
      SEQ_SCAN_TEST: begin
        clr_en = 1'b1;
      end
      SEQ_DATA_EMIT: begin
        clr_en = out_load;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE:       if (item_valid && opcode) state_next = SEQ_LOAD;
      SEQ_LOAD:       state_next = SEQ_CLASSIFY;
      SEQ_CLASSIFY:   state_next = SEQ_SCAN_CHECK;
      SEQ_SCAN_CHECK: state_next = gap_done ? SEQ_STATUS : SEQ_SCAN_STEP;
      SEQ_SCAN_STEP:  state_next = SEQ_SCAN_TEST;
      SEQ_SCAN_TEST: begin
        if (!is_header) begin
          state_next = SEQ_SCAN_CHECK;
        end else if (len == 5'd0) begin
          state_next = SEQ_FRAME_END;
        end else begin
          state_next = SEQ_DATA_STEP;
        end
      end
      SEQ_DATA_STEP:  state_next = SEQ_DATA_EMIT;
      SEQ_DATA_EMIT: begin
        if (out_load) begin
          state_next = last_byte ? SEQ_FRAME_END : SEQ_DATA_STEP;
        end
      end
      SEQ_FRAME_END:  state_next = frame_stop ? SEQ_STATUS : SEQ_SCAN_CHECK;
      SEQ_STATUS:     if (out_load) state_next = SEQ_IDLE;
      default:        state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= SEQ_IDLE;
      w            <= '0;
      prev_w       <= '0;
      r            <= '0;
      stall_cnt    <= '0;
      ov_cnt       <= '0;
      outcome      <= OUTCOME_NORMAL;
      byte_idx     <= '0;
      n_cnt        <= '0;
      frame_id     <= FRAME_ID_RESET;
      resync       <= RESYNC_RESET;
      frame_len    <= FRAME_LEN_RESET;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_ID:  frame_id  <= cfg_data[2:0];
          REG_RESYNC:    resync    <= cfg_data;
          REG_FRAME_LEN: frame_len <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
      if (wr_en) begin
        w <= ptr_res;
      end
      unique case (state)
        SEQ_CLASSIFY: begin
          n_cnt <= '0;
          if (!is_empty) begin
            ov_cnt  <= sat_inc(ov_cnt);
            outcome <= OUTCOME_OVERRUN;
            r       <= ptr_res;
          end else if ((w != r) && (w != prev_w)) begin
            stall_cnt <= '0;
            outcome   <= OUTCOME_NORMAL;
          end else begin
            stall_cnt <= sat_inc(stall_cnt);
            outcome   <= OUTCOME_STALLED;
          end
        end
        SEQ_SCAN_STEP, SEQ_DATA_STEP: r <= ptr_res;
        SEQ_SCAN_TEST: byte_idx <= '0;
        SEQ_DATA_EMIT: begin
          if (out_load) begin
            byte_idx <= byte_idx + 5'd1;
            n_cnt    <= n_cnt + 6'd1;
          end
        end
        SEQ_STATUS: if (out_load) prev_w <= w;
        default: begin
        end
      endcase
      if (load_data || load_status) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_data) begin
      item_kind       <= KIND_DATA;
      byte_index      <= byte_idx;
      frame_byte      <= rd_data;
      poll_outcome    <= '0;
      stall_total     <= '0;
      overrun_total   <= '0;
      reader_position <= '0;
      last_of_run     <= 1'b0;
    end else if (load_status) begin
      item_kind       <= KIND_STATUS;
      byte_index      <= '0;
      frame_byte      <= '0;
      poll_outcome    <= outcome;
      stall_total     <= stall_cnt;
      overrun_total   <= ov_cnt;
      reader_position <= 6'(r);
      last_of_run     <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (stall_cnt <= COUNT_CAP) && (ov_cnt <= COUNT_CAP))
    else $error("saturating count above cap");

  a_emit_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_DATA_EMIT) |-> ((byte_idx < len) && ({1'b0, n_cnt} < RESULT_ROOM)))
    else $error("data transfer out of frame or result bounds");

  a_status_out: assert property (@(posedge clk) disable iff (rst)
    ((state == SEQ_STATUS) && out_load) |=> (result_valid && last_of_run &&
                                             (state == SEQ_IDLE)))
    else $error("status transfer not presented at end of poll");
`endif

endmodule
